FILE: rtl/memory_region_table_checker_assert.svh
`ifndef MEMORY_REGION_TABLE_CHECKER_ASSERT_SVH
`define MEMORY_REGION_TABLE_CHECKER_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during reset
`define MRTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define MRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/mrtc_pkg.sv
package mrtc_pkg;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam logic [31:0] PAGE_MASK  = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [32:0] PAGE_BYTES = 33'(64'd1 << PAGE_SHIFT);

  localparam logic [1:0] FLAG_READ  = 2'd0;
  localparam logic [1:0] FLAG_WRITE = 2'd1;
  localparam logic [1:0] FLAG_STACK = 2'd2;

  typedef enum logic [1:0] {
    REQ_MAP    = 2'd0,
    REQ_CHECK  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_OVERLAP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_USER_BASE   = 2'd0,
    REG_USER_TOP    = 2'd1,
    REG_KERNEL_BASE = 2'd2,
    REG_KERNEL_TOP  = 2'd3
  } reg_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] limit;
    logic [2:0]  perms;
  } region_t;

  typedef struct packed {
    logic [31:0] user_lo;
    logic [31:0] user_hi;
    logic [31:0] kern_lo;
    logic [31:0] kern_hi;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_START,
    S_FIND_EV_LAST,
    S_FIND_RD,
    S_FIND_EV,
    S_POS_RD,
    S_POS_EV,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS,
    S_RESP
  } state_t;

endpackage

FILE: rtl/mrtc_if.sv
interface mrtc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] address;
  logic [31:0] length;
  logic [2:0]  new_flags;
  logic        want_write;
  logic        kernel_caller;

  modport source (output valid, req_type, address, length, new_flags, want_write,
                  kernel_caller, input ready);
  modport sink (input valid, req_type, address, length, new_flags, want_write,
                kernel_caller, output ready);
endinterface

interface mrtc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        allowed;
  logic        hit;
  logic [31:0] found_start;
  logic [31:0] found_end;
  logic [2:0]  found_flags;

  modport source (output valid, status, allowed, hit, found_start, found_end, found_flags,
                  input ready);
  modport sink (input valid, status, allowed, hit, found_start, found_end, found_flags,
                output ready);
endinterface

FILE: rtl/memory_region_table_checker.sv
// Region table checker. Holds up to MAX_REGIONS regions sorted by start in a
// single-port-read table and serves map, check-access and lookup requests one
// at a time; req.ready is high only while the sequencer is idle. Every table
// access is an address then a registered read; a lookup probes entries one at
// a time, a map adds a scan of entries for the insert point and a shift of
// entries up, and a user access check repeats a lookup for each region the
// range crosses. Requests decided from the registers alone (kernel checks,
// invalid ranges) skip the table. The result sits in an output register, so
// the next request is taken while it waits. The user must write the register
// file over the APB port only while idle; the block does not enforce it.
module memory_region_table_checker #(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  mrtc_req_if.sink    req,
  mrtc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

  mrtc_pkg::cfg_t    cfg;
  mrtc_pkg::state_t  state, state_next;
  mrtc_pkg::region_t rdata, wdata;
  logic              we;
  logic [IW-1:0]     waddr, raddr;

  mrtc_pkg::req_t    kind;
  logic              wr;
  logic [2:0]        flags;
  logic [31:0]       cur, lim;
  logic [CW-1:0]     count, idx, j;
  logic [IW-1:0]     last_hit;
  logic              hit_valid;
  logic [31:0]       prior_limit;
  logic              have_prev;

  logic [1:0]        res_status;
  logic              res_allowed, res_hit;
  logic [31:0]       res_start, res_end;
  logic [2:0]        res_flags;

  logic              accept;
  logic [31:0]       map_s, map_e, chk_e;
  logic              map_ok, user_ok, kern_ok;
  logic              holds, find_miss, chk_fail, more, full, pos_conflict;

  assign pready = 1'b1;

  mrtc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mrtc_table #(.DEPTH(MAX_REGIONS), .AW(IW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready = (state == mrtc_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;

  assign map_s   = req.address & ~mrtc_pkg::PAGE_MASK;
  assign map_e   = (req.address + req.length + mrtc_pkg::PAGE_MASK) & ~mrtc_pkg::PAGE_MASK;
  assign chk_e   = req.address + req.length;
  assign map_ok  = cfg.user_lo <= map_s && map_s < map_e && map_e <= cfg.user_hi;
  assign user_ok = cfg.user_lo <= req.address && req.address < chk_e &&
                   chk_e <= cfg.user_hi;
  assign kern_ok = cfg.kern_lo <= req.address && req.address < chk_e &&
                   chk_e <= cfg.kern_hi;

  assign holds     = rdata.base <= cur && rdata.limit > cur;
  assign find_miss = (state == mrtc_pkg::S_FIND_RD) && (idx >= count);
  assign chk_fail  = !rdata.perms[wr ? mrtc_pkg::FLAG_WRITE : mrtc_pkg::FLAG_READ] ||
                     (wr && rdata.perms[mrtc_pkg::FLAG_STACK] &&
                      ({1'b0, cur} < {1'b0, rdata.base} + mrtc_pkg::PAGE_BYTES));
  assign more      = rdata.limit < lim;
  assign full      = (count == CW'(MAX_REGIONS));
  assign pos_conflict = (have_prev && prior_limit > cur) || (lim > rdata.base);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mrtc_pkg::S_IDLE: begin
        if (accept) begin
          unique case (mrtc_pkg::req_t'(req.req_type))
            mrtc_pkg::REQ_MAP:
              state_next = map_ok ? mrtc_pkg::S_FIND_START : mrtc_pkg::S_RESP;
            mrtc_pkg::REQ_CHECK:
              state_next = (!req.kernel_caller && user_ok) ? mrtc_pkg::S_FIND_START
                                                            : mrtc_pkg::S_RESP;
            mrtc_pkg::REQ_LOOKUP: state_next = mrtc_pkg::S_FIND_START;
            default:              state_next = mrtc_pkg::S_RESP;
          endcase
        end
      end
      mrtc_pkg::S_FIND_START:
        state_next = (hit_valid && CW'(last_hit) < count) ? mrtc_pkg::S_FIND_EV_LAST
                                                          : mrtc_pkg::S_FIND_RD;
      mrtc_pkg::S_FIND_EV_LAST, mrtc_pkg::S_FIND_EV: begin
        if (holds) begin
          if (kind == mrtc_pkg::REQ_CHECK && !chk_fail && more) begin
            state_next = mrtc_pkg::S_FIND_START;
          end else begin
            state_next = mrtc_pkg::S_RESP;
          end
        end else begin
          state_next = mrtc_pkg::S_FIND_RD;
        end
      end
      mrtc_pkg::S_FIND_RD: begin
        if (find_miss) begin
          state_next = (kind == mrtc_pkg::REQ_MAP && !full) ? mrtc_pkg::S_POS_RD
                                                            : mrtc_pkg::S_RESP;
        end else begin
          state_next = mrtc_pkg::S_FIND_EV;
        end
      end
      mrtc_pkg::S_POS_RD: begin
        if (idx < count) begin
          state_next = mrtc_pkg::S_POS_EV;
        end else begin
          state_next = (have_prev && prior_limit > cur) ? mrtc_pkg::S_RESP
                                                        : mrtc_pkg::S_SHIFT_RD;
        end
      end
      mrtc_pkg::S_POS_EV: begin
        priority if (rdata.base <= cur) state_next = mrtc_pkg::S_POS_RD;
        else if (pos_conflict)          state_next = mrtc_pkg::S_RESP;
        else                            state_next = mrtc_pkg::S_SHIFT_RD;
      end
      mrtc_pkg::S_SHIFT_RD:
        state_next = (j > idx) ? mrtc_pkg::S_SHIFT_WR : mrtc_pkg::S_INS;
      mrtc_pkg::S_SHIFT_WR: state_next = mrtc_pkg::S_SHIFT_RD;
      mrtc_pkg::S_INS:      state_next = mrtc_pkg::S_RESP;
      mrtc_pkg::S_RESP:
        if (!rsp.valid || rsp.ready) state_next = mrtc_pkg::S_IDLE;
      default: state_next = mrtc_pkg::S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = j[IW-1:0];
    wdata = rdata;
    raddr = idx[IW-1:0];
    unique case (state)
      mrtc_pkg::S_FIND_START: raddr = last_hit;
      mrtc_pkg::S_SHIFT_RD:   raddr = IW'(j - CW'(1));
      mrtc_pkg::S_SHIFT_WR:   we = 1'b1;
      mrtc_pkg::S_INS: begin
        we    = 1'b1;
        waddr = idx[IW-1:0];
        wdata = '{base: cur, limit: lim, perms: flags};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrtc_pkg::S_IDLE;
      count     <= '0;
      hit_valid <= 1'b0;
      last_hit  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mrtc_pkg::S_RESP && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (state == mrtc_pkg::S_FIND_EV && holds) begin
        hit_valid <= 1'b1;
        last_hit  <= idx[IW-1:0];
      end
      if (state == mrtc_pkg::S_INS) begin
        count <= count + CW'(1);
        if (hit_valid && CW'(last_hit) >= idx) last_hit <= last_hit + IW'(1);
      end
    end
  end

  // datapath and result words
  always_ff @(posedge clk) begin
    unique case (state)
      mrtc_pkg::S_IDLE: begin
        if (accept) begin
          kind        <= mrtc_pkg::req_t'(req.req_type);
          wr          <= req.want_write;
          flags       <= req.new_flags;
          res_status  <= (mrtc_pkg::req_t'(req.req_type) == mrtc_pkg::REQ_MAP && !map_ok) ?
                         mrtc_pkg::ST_INVALID : mrtc_pkg::ST_OK;
          res_allowed <= (mrtc_pkg::req_t'(req.req_type) == mrtc_pkg::REQ_CHECK &&
                          req.kernel_caller) ? kern_ok : 1'b0;
          res_hit     <= 1'b0;
          res_start   <= '0;
          res_end     <= '0;
          res_flags   <= '0;
          if (mrtc_pkg::req_t'(req.req_type) == mrtc_pkg::REQ_MAP) begin
            cur <= map_s;
            lim <= map_e;
          end else begin
            cur <= req.address;
            lim <= chk_e;
          end
        end
      end
      mrtc_pkg::S_FIND_START: idx <= '0;
      mrtc_pkg::S_FIND_EV_LAST, mrtc_pkg::S_FIND_EV: begin
        if (holds) begin
          unique case (kind)
            mrtc_pkg::REQ_MAP: res_status <= mrtc_pkg::ST_INVALID;
            mrtc_pkg::REQ_LOOKUP: begin
              res_hit   <= 1'b1;
              res_start <= rdata.base;
              res_end   <= rdata.limit;
              res_flags <= rdata.perms;
            end
            mrtc_pkg::REQ_CHECK: begin
              cur <= rdata.limit;
              if (!chk_fail && !more) res_allowed <= 1'b1;
            end
            default: ;
          endcase
        end else if (state == mrtc_pkg::S_FIND_EV) begin
          idx <= idx + CW'(1);
        end
      end
      mrtc_pkg::S_FIND_RD: begin
        if (find_miss && kind == mrtc_pkg::REQ_MAP) begin
          idx       <= '0;
          have_prev <= 1'b0;
          if (full) res_status <= mrtc_pkg::ST_FULL;
        end
      end
      mrtc_pkg::S_POS_RD: begin
        j <= count;
        if (idx >= count && have_prev && prior_limit > cur) res_status <= mrtc_pkg::ST_OVERLAP;
      end
      mrtc_pkg::S_POS_EV: begin
        if (rdata.base <= cur) begin
          prior_limit <= rdata.limit;
          have_prev   <= 1'b1;
          idx         <= idx + CW'(1);
        end else if (pos_conflict) begin
          res_status <= mrtc_pkg::ST_OVERLAP;
        end
      end
      mrtc_pkg::S_SHIFT_WR: j <= j - CW'(1);
      mrtc_pkg::S_INS: begin
        res_hit   <= 1'b1;
        res_start <= cur;
        res_end   <= lim;
        res_flags <= flags;
      end
      mrtc_pkg::S_RESP: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.status      <= res_status;
          rsp.allowed     <= res_allowed;
          rsp.hit         <= res_hit;
          rsp.found_start <= res_start;
          rsp.found_end   <= res_end;
          rsp.found_flags <= res_flags;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/mrtc_cfg.sv
module mrtc_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output mrtc_pkg::cfg_t   cfg
);

  mrtc_pkg::reg_t sel;

  assign sel = mrtc_pkg::reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_lo <= 32'h0020_0000;
      cfg.user_hi <= 32'hB000_0000;
      cfg.kern_lo <= 32'hC000_0000;
      cfg.kern_hi <= 32'hF800_0000;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        mrtc_pkg::REG_USER_BASE:   cfg.user_lo <= pwdata;
        mrtc_pkg::REG_USER_TOP:    cfg.user_hi <= pwdata;
        mrtc_pkg::REG_KERNEL_BASE: cfg.kern_lo <= pwdata;
        mrtc_pkg::REG_KERNEL_TOP:  cfg.kern_hi <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      mrtc_pkg::REG_USER_BASE:   prdata = cfg.user_lo;
      mrtc_pkg::REG_USER_TOP:    prdata = cfg.user_hi;
      mrtc_pkg::REG_KERNEL_BASE: prdata = cfg.kern_lo;
      mrtc_pkg::REG_KERNEL_TOP:  prdata = cfg.kern_hi;
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/mrtc_table.sv
module mrtc_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  mrtc_pkg::region_t  wdata,
  input  logic [AW-1:0]      raddr,
  output mrtc_pkg::region_t  rdata
);

  mrtc_pkg::region_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mrtc_checker.sv
`include "memory_region_table_checker_assert.svh"

module mrtc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        allowed,
  input logic        hit,
  input logic [31:0] found_start,
  input logic [31:0] found_end,
  input logic [2:0]  found_flags
);

  `MRTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
  `MRTC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken")
  `MRTC_ASSERT_NOW(a_hit_range, out_valid && hit, found_start < found_end, "empty region")
  `MRTC_ASSERT_NOW(a_miss_zero, out_valid && !hit,
                   found_start == 32'd0 && found_end == 32'd0 && found_flags == 3'd0,
                   "stale region fields")
  `MRTC_ASSERT_NOW(a_allowed_alone, out_valid && allowed,
                   status == mrtc_pkg::ST_OK && !hit,
                   "mixed result fields")

endmodule

bind memory_region_table_checker mrtc_checker u_mrtc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .status      (rsp.status),
  .allowed     (rsp.allowed),
  .hit         (rsp.hit),
  .found_start (rsp.found_start),
  .found_end   (rsp.found_end),
  .found_flags (rsp.found_flags)
);

FILE: sim/memory_region_table_checker_tb.sv
`timescale 1ns / 100ps

module memory_region_table_checker_tb;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef struct {
    mrtc_pkg::req_t kind;
    logic [31:0]    addr;
    logic [31:0]    len;
    logic [2:0]     flags;
    logic           wr;
    logic           kern;
  } request_t;

  typedef struct {
    mrtc_pkg::status_t status;
    logic              allowed;
    logic              hit;
    logic [31:0]       start_a;
    logic [31:0]       end_a;
    logic [2:0]        flags;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned rsp_hold_left = 0;

  mrtc_req_if req_bus ();
  mrtc_rsp_if rsp_bus ();

  memory_region_table_checker #(.MAX_REGIONS(TABLE_DEPTH)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block's registers and region table
  logic [31:0] sh_user_lo = 32'h0020_0000;
  logic [31:0] sh_user_hi = 32'hB000_0000;
  logic [31:0] sh_kern_base = 32'hC000_0000;
  logic [31:0] sh_kern_top = 32'hF800_0000;
  logic [31:0] tbl_start [TABLE_DEPTH];
  logic [31:0] tbl_end [TABLE_DEPTH];
  logic [2:0]  tbl_flags [TABLE_DEPTH];
  int unsigned tbl_count = 0;
  bit          last_ok = 1'b0;
  int unsigned last_idx = 0;

  answer_t pending_answers[$];

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("memory_region_table_checker_tb: done, errors");
      $finish;
    end
  end

  function automatic bit region_holds(int unsigned i, logic [31:0] a);
    return tbl_start[i] <= a && tbl_end[i] > a;
  endfunction

  function automatic int find_region(logic [31:0] a);
    if (last_ok && last_idx < tbl_count && region_holds(last_idx, a))
      return last_idx;
    for (int unsigned i = 0; i < tbl_count; i++) begin
      if (region_holds(i, a)) begin
        last_ok = 1'b1;
        last_idx = i;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic bit in_user_space(logic [31:0] s, logic [31:0] e);
    return sh_user_lo <= s && s < e && e <= sh_user_hi;
  endfunction

  function automatic mrtc_pkg::status_t map_region(request_t r, output int unsigned pos);
    logic [31:0] s;
    logic [31:0] e;
    int unsigned p;
    s = r.addr & ~mrtc_pkg::PAGE_MASK;
    e = (r.addr + r.len + mrtc_pkg::PAGE_MASK) & ~mrtc_pkg::PAGE_MASK;
    pos = 0;
    if (!in_user_space(s, e)) return mrtc_pkg::ST_INVALID;
    if (find_region(s) >= 0) return mrtc_pkg::ST_INVALID;
    if (tbl_count >= TABLE_DEPTH) return mrtc_pkg::ST_FULL;
    p = 0;
    while (p < tbl_count && tbl_start[p] <= s) p++;
    if (p > 0 && tbl_end[p-1] > s) return mrtc_pkg::ST_OVERLAP;
    if (p < tbl_count && e > tbl_start[p]) return mrtc_pkg::ST_OVERLAP;
    for (int unsigned i = tbl_count; i > p; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_end[i] = tbl_end[i-1];
      tbl_flags[i] = tbl_flags[i-1];
    end
    tbl_start[p] = s;
    tbl_end[p] = e;
    tbl_flags[p] = r.flags;
    tbl_count++;
    if (last_ok && last_idx >= p) last_idx++;
    pos = p;
    return mrtc_pkg::ST_OK;
  endfunction

  function automatic logic access_permitted(request_t r);
    logic [31:0] e;
    logic [31:0] cur;
    int idx;
    e = r.addr + r.len;
    cur = r.addr;
    if (r.kern) return sh_kern_base <= r.addr && r.addr < e && e <= sh_kern_top;
    if (!in_user_space(r.addr, e)) return 1'b0;
    while (cur < e) begin
      idx = find_region(cur);
      if (idx < 0) return 1'b0;
      if (cur < tbl_start[idx]) return 1'b0;
      if (!tbl_flags[idx][r.wr ? mrtc_pkg::FLAG_WRITE : mrtc_pkg::FLAG_READ]) return 1'b0;
      // the lowest page of a stack stays unwritable
      if (r.wr && tbl_flags[idx][mrtc_pkg::FLAG_STACK] &&
          {1'b0, cur} < {1'b0, tbl_start[idx]} + mrtc_pkg::PAGE_BYTES)
        return 1'b0;
      cur = tbl_end[idx];
    end
    return 1'b1;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int unsigned pos;
    int idx;
    a = '{status: mrtc_pkg::ST_OK, allowed: 1'b0, hit: 1'b0, start_a: '0, end_a: '0,
          flags: '0};
    idx = -1;
    case (r.kind)
      mrtc_pkg::REQ_MAP: begin
        a.status = map_region(r, pos);
        if (a.status == mrtc_pkg::ST_OK) idx = pos;
      end
      mrtc_pkg::REQ_CHECK: a.allowed = access_permitted(r);
      mrtc_pkg::REQ_LOOKUP: idx = find_region(r.addr);
      default: ;
    endcase
    if (idx >= 0) begin
      a.hit = 1'b1;
      a.start_a = tbl_start[idx];
      a.end_a = tbl_end[idx];
      a.flags = tbl_flags[idx];
    end
    return a;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 11) == 0) return $urandom_range(15, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Sender: gap, then hold the word until the block takes it
  task automatic send_request(request_t r, bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= r.kind;
    req_bus.address <= r.addr;
    req_bus.length <= r.len;
    req_bus.new_flags <= r.flags;
    req_bus.want_write <= r.wr;
    req_bus.kernel_caller <= r.kern;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pending_answers.push_back(predict_answer(r));
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(mrtc_pkg::reg_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      mrtc_pkg::REG_USER_BASE: sh_user_lo = value;
      mrtc_pkg::REG_USER_TOP: sh_user_hi = value;
      mrtc_pkg::REG_KERNEL_BASE: sh_kern_base = value;
      default: sh_kern_top = value;
    endcase
  endtask

  task automatic set_spaces(logic [31:0] ub, logic [31:0] ut, logic [31:0] kb,
                            logic [31:0] kt);
    wait_drained();
    write_register(mrtc_pkg::REG_USER_BASE, ub);
    write_register(mrtc_pkg::REG_USER_TOP, ut);
    write_register(mrtc_pkg::REG_KERNEL_BASE, kb);
    write_register(mrtc_pkg::REG_KERNEL_TOP, kt);
  endtask

  function automatic request_t make_req(mrtc_pkg::req_t k, logic [31:0] a, logic [31:0] l,
                                        logic [2:0] f = 3'd0, logic w = 1'b0,
                                        logic kc = 1'b0);
    return '{kind: k, addr: a, len: l, flags: f, wr: w, kern: kc};
  endfunction

  function automatic logic [31:0] any_user_addr();
    if (sh_user_hi > sh_user_lo) return $urandom_range(sh_user_lo, sh_user_hi - 1);
    return $urandom;
  endfunction

  // Mostly requests aimed at the mapped regions, the rest noise
  function automatic request_t random_request();
    request_t r;
    int unsigned i;
    int unsigned j;
    int unsigned sel;
    r = make_req(mrtc_pkg::REQ_NONE, $urandom, $urandom, 3'($urandom), 1'($urandom),
                 1'($urandom));
    sel = $urandom_range(0, 99);
    i = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
    if (sel < 35) begin
      r.kind = mrtc_pkg::REQ_MAP;
      r.len = $urandom_range(1, 32'h6000);
      if (tbl_count > 0 && $urandom_range(0, 1)) r.addr = tbl_end[i] + $urandom_range(0, 32'h1800);
      else r.addr = any_user_addr();
    end else if (sel < 65 && tbl_count > 0) begin
      r.kind = mrtc_pkg::REQ_CHECK;
      r.kern = 1'b0;
      j = (i + 1 < tbl_count && $urandom_range(0, 1)) ? i + 1 : i;
      r.addr = tbl_start[i] + $urandom_range(0, tbl_end[i] - tbl_start[i] - 1);
      r.len = $urandom_range(1, tbl_end[j] - r.addr + ($urandom_range(0, 3) == 0 ? 32'h10 : 0));
    end else if (sel < 75) begin
      r.kind = mrtc_pkg::REQ_CHECK;
      r.kern = 1'b1;
      r.addr = (sh_kern_top > sh_kern_base) ? $urandom_range(sh_kern_base, sh_kern_top) : $urandom;
      r.len = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000);
    end else if (sel < 95) begin
      r.kind = mrtc_pkg::REQ_LOOKUP;
      if (tbl_count > 0 && $urandom_range(0, 3) != 0)
        r.addr = tbl_start[i] + $urandom_range(0, tbl_end[i] - tbl_start[i]);
    end else begin
      r.kind = mrtc_pkg::req_t'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic run_random(int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_request(random_request());
  endtask

  task automatic test_directed();
    logic [31:0] ub;
    ub = sh_user_lo;
    send_request(make_req(mrtc_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0));
    send_request(make_req(mrtc_pkg::REQ_CHECK, ub, 32'h10));
    send_request(make_req(mrtc_pkg::REQ_CHECK, sh_kern_base, sh_kern_top - sh_kern_base,
                          3'd0, 1'b1, 1'b1));
    send_request(make_req(mrtc_pkg::REQ_CHECK, sh_kern_base, 32'h0, 3'd0, 1'b0, 1'b1));
    send_request(make_req(mrtc_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1,
                          1'b1));
    send_request(make_req(mrtc_pkg::REQ_MAP, ub + 32'h0123, 32'h1000, 3'd3));
    send_request(make_req(mrtc_pkg::REQ_MAP, ub + 32'h1000, 32'h2000, 3'd7));
    send_request(make_req(mrtc_pkg::REQ_MAP, ub + 32'h3000, 32'h1000, 3'd1));
    send_request(make_req(mrtc_pkg::REQ_MAP, ub + 32'h5000, 32'h0, 3'd3));
    send_request(make_req(mrtc_pkg::REQ_MAP, ub + 32'h1800, 32'h10, 3'd3));
    send_request(make_req(mrtc_pkg::REQ_MAP, ub - 32'h1000, 32'h2000, 3'd3));
    send_request(make_req(mrtc_pkg::REQ_MAP, sh_user_hi - 32'h1000, 32'h2000, 3'd3));
    send_request(make_req(mrtc_pkg::REQ_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7));
    send_request(make_req(mrtc_pkg::REQ_MAP, 32'h0000_0000, 32'h0, 3'd0));
    send_request(make_req(mrtc_pkg::REQ_CHECK, ub + 32'h10, 32'h3ff0, 3'd0, 1'b0));
    send_request(make_req(mrtc_pkg::REQ_CHECK, ub + 32'h10, 32'h1ff0, 3'd0, 1'b1));
    send_request(make_req(mrtc_pkg::REQ_CHECK, ub + 32'h2000, 32'h100, 3'd0, 1'b1));
    send_request(make_req(mrtc_pkg::REQ_CHECK, ub + 32'h3000, 32'h100, 3'd0, 1'b1));
    send_request(make_req(mrtc_pkg::REQ_CHECK, ub + 32'h3800, 32'h1000, 3'd0, 1'b0));
    send_request(make_req(mrtc_pkg::REQ_LOOKUP, ub + 32'h2fff, 32'h0));
    send_request(make_req(mrtc_pkg::REQ_LOOKUP, ub + 32'h4000, 32'h0));
    send_request(make_req(mrtc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0));
    send_request(make_req(mrtc_pkg::REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1,
                          1'b1));
  endtask

  task automatic test_table_full();
    for (int unsigned k = 0; k < TABLE_DEPTH + 2; k++)
      send_request(make_req(mrtc_pkg::REQ_MAP, sh_user_hi - 32'h0100_0000 + k * 32'h4000,
                            32'h2000, 3'($urandom)));
  endtask

  task automatic test_register_extremes();
    set_spaces(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    run_random(60);
    set_spaces(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    run_random(30);
    set_spaces(32'h0020_0000, 32'hB000_0000, 32'hC000_0000, 32'hF800_0000);
  endtask

  task automatic test_output_stall();
    rsp_hold_left = 400;
    for (int unsigned k = 0; k < 20; k++) send_request(random_request(), 1'b0);
  endtask

  task automatic test_drained_bursts();
    for (int unsigned k = 0; k < 4; k++) begin
      run_random(10);
      wait_drained();
    end
  endtask

  // Receiver ready, with random stalls and a counted hold-off
  initial begin
    int unsigned stall;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        rsp_hold_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        rsp_bus.ready <= (stall == 0);
        if (stall > 0) begin
          repeat (stall) @(posedge clk);
          rsp_bus.ready <= 1'b1;
        end
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result word");
        mismatches++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (rsp_bus.status !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, rsp_bus.status);
          mismatches++;
        end
        if (rsp_bus.allowed !== exp_a.allowed) begin
          $error("allowed: expected %0d, got %0d", exp_a.allowed, rsp_bus.allowed);
          mismatches++;
        end
        if (rsp_bus.hit !== exp_a.hit) begin
          $error("hit: expected %0d, got %0d", exp_a.hit, rsp_bus.hit);
          mismatches++;
        end
        if (rsp_bus.found_start !== exp_a.start_a) begin
          $error("found_start: expected %h, got %h", exp_a.start_a, rsp_bus.found_start);
          mismatches++;
        end
        if (rsp_bus.found_end !== exp_a.end_a) begin
          $error("found_end: expected %h, got %h", exp_a.end_a, rsp_bus.found_end);
          mismatches++;
        end
        if (rsp_bus.found_flags !== exp_a.flags) begin
          $error("found_flags: expected %0d, got %0d", exp_a.flags, rsp_bus.found_flags);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.req_type = mrtc_pkg::REQ_NONE;
    req_bus.address = '0;
    req_bus.length = '0;
    req_bus.new_flags = '0;
    req_bus.want_write = 1'b0;
    req_bus.kernel_caller = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_spaces(32'h0020_0000, 32'hB000_0000, 32'hC000_0000, 32'hF800_0000);
    run_random(200);
    test_output_stall();
    test_drained_bursts();
    test_table_full();
    test_register_extremes();
    run_random(100);
    wait_drained();
    if (mismatches == 0) begin
      $display("memory_region_table_checker_tb: done, clean");
    end else begin
      $display("memory_region_table_checker_tb: done, errors");
    end
    $finish;
  end

endmodule
